// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the gradient ramp design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: design/grcl_pkg.sv
// ----------------------------------------------------------------------------
// grcl_pkg
// Shared constants and types for the gradient ramp color lookup.
// ----------------------------------------------------------------------------
package grcl_pkg;

  localparam int MAX_STOPS_DEF = 8;
  localparam int FRAC_BITS_DEF = 16;

  localparam int CH_W    = 8;
  localparam int NUM_CH  = 4;
  localparam int COLOR_W = CH_W * NUM_CH;
  localparam int SLOT_W  = 3;
  localparam int CNT_W   = 4;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // packed r, g, b, a from the top byte down
  localparam logic [COLOR_W-1:0] COLOR_BLACK = 32'h000000FF;
  localparam logic [COLOR_W-1:0] COLOR_WHITE = 32'hFFFFFFFF;

  typedef struct packed {
    logic busy;
    logic done;
  } blend_sts_t;

endpackage

// File: design/grcl_ram.sv
// ----------------------------------------------------------------------------
// grcl_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module grcl_ram #(
  parameter int WIDTH = 49,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/grcl_blend.sv
// ----------------------------------------------------------------------------
// grcl_blend
// Four-lane channel interpolator: a multiply state, then a shared
// restoring divide by twice the span, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grcl_blend #(
  parameter int PW = grcl_pkg::FRAC_BITS_DEF + 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [grcl_pkg::COLOR_W-1:0] color_lo,
  input  logic [grcl_pkg::COLOR_W-1:0] color_hi,
  input  logic [PW-1:0]                span,
  input  logic [PW-1:0]                offs,
  output grcl_pkg::blend_sts_t         sts,
  output logic [grcl_pkg::COLOR_W-1:0] result
);

  localparam int CH_W   = grcl_pkg::CH_W;
  localparam int NUM_CH = grcl_pkg::NUM_CH;
  localparam int CW     = grcl_pkg::COLOR_W;
  localparam int PRW    = PW + CH_W;
  localparam int NW     = PW + CH_W + 2;
  localparam int SW     = $clog2(CH_W);

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_DIV} bstate_t;

  bstate_t         state_r;
  logic            done_r;
  logic [CW-1:0]   clo_r;
  logic [CW-1:0]   chi_r;
  logic [PW-1:0]   span_r;
  logic [PW-1:0]   offs_r;
  logic [NW-1:0]   dsh_r;
  logic [SW-1:0]   step_r;
  logic [NW-1:0]   rem_r [NUM_CH];
  logic [CH_W-1:0] q_r   [NUM_CH];

  logic [PW-1:0]   rest;
  logic [PRW-1:0]  prod_a [NUM_CH];
  logic [PRW-1:0]  prod_b [NUM_CH];
  logic [NW-1:0]   num    [NUM_CH];

  // num = 2*x*(span-d) + 2*y*d + span, never negative and below 256*2*span
  always_comb begin
    rest = span_r - offs_r;
    for (int k = 0; k < NUM_CH; k++) begin
      prod_a[k] = PRW'(clo_r[(CW-1-k*CH_W) -: CH_W]) * PRW'(rest);
      prod_b[k] = PRW'(chi_r[(CW-1-k*CH_W) -: CH_W]) * PRW'(offs_r);
      num[k]    = (NW'(prod_a[k]) << 1) + (NW'(prod_b[k]) << 1) + NW'(span_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == B_DIV) && (step_r == SW'(CH_W - 1));
      case (state_r)
        B_IDLE: begin
          if (start) begin
            clo_r   <= color_lo;
            chi_r   <= color_hi;
            span_r  <= span;
            offs_r  <= offs;
            state_r <= B_MUL;
          end
        end
        B_MUL: begin
          for (int k = 0; k < NUM_CH; k++) begin
            rem_r[k] <= num[k];
            q_r[k]   <= '0;
          end
          dsh_r   <= NW'({span_r, 1'b0}) << (CH_W - 1);
          step_r  <= '0;
          state_r <= B_DIV;
        end
        B_DIV: begin
          for (int k = 0; k < NUM_CH; k++) begin
            if (rem_r[k] >= dsh_r) begin
              rem_r[k] <= rem_r[k] - dsh_r;
              q_r[k]   <= {q_r[k][CH_W-2:0], 1'b1};
            end else begin
              q_r[k]   <= {q_r[k][CH_W-2:0], 1'b0};
            end
          end
          dsh_r  <= dsh_r >> 1;
          step_r <= step_r + 1'b1;
          if (step_r == SW'(CH_W - 1)) begin
            state_r <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      result[(CW-1-k*CH_W) -: CH_W] = q_r[k];
    end
  end

  assign sts.busy = (state_r != B_IDLE);
  assign sts.done = done_r;

endmodule

// File: design/gradient_ramp_color_lookup.sv
// ----------------------------------------------------------------------------
// gradient_ramp_color_lookup
// Multi-stop linear color ramp: stop table in a RAM, scanned per query.
// ----------------------------------------------------------------------------
// Usage:
//   in_* is a request stream. in_tuser low loads one stop (slot, position,
//   rgba) into the stop table; in_tuser high evaluates the ramp at query_pos.
//   out_* carries one rgba color per evaluate request, none for a load.
//   cfg_we/cfg_wdata sets the number of stops in use; write it while idle.
// Timing:
//   a load keeps the input ready, and the next request is taken right after.
//   an evaluate reads the last stop, then scans from slot 0; one clamped to
//   the first or last stop ends at slot 0, an interpolated one scans on to
//   the upper bracketing stop and then blends. the scan reads one stop per
//   cycle through the table's single read port, and the blend unit spends
//   a multiply state plus 8 divide steps.
// Reset:
//   restores two stops (0.0 black, 1.0 white) with stop count 2; per-slot
//   valid bits make unwritten slots read as their reset value.
// Stall:
//   a result waits in the output register; the next request is still taken
//   and worked on, and holds only at the hand-off while the register is full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gradient_ramp_color_lookup #(
  parameter int MAX_STOPS = grcl_pkg::MAX_STOPS_DEF,
  parameter int FRAC_BITS = grcl_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [grcl_pkg::CNT_W-1:0]   cfg_wdata,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // stop_slot, stop_pos, stop_red, stop_green, stop_blue, stop_alpha,
  // query_pos, zero fill
  input  logic [((grcl_pkg::SLOT_W + 2*(FRAC_BITS+1) + grcl_pkg::COLOR_W + 7) / 8) * 8 - 1:0]
                                       in_tdata,
  // cmd
  input  logic                         in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [grcl_pkg::COLOR_W-1:0] out_tdata
);

  localparam int CH_W   = grcl_pkg::CH_W;
  localparam int CW     = grcl_pkg::COLOR_W;
  localparam int SLOT_W = grcl_pkg::SLOT_W;
  localparam int CNT_W  = grcl_pkg::CNT_W;
  localparam int PW     = FRAC_BITS + 1;
  localparam int AW     = $clog2(MAX_STOPS);
  localparam int EW     = PW + CW;
  localparam logic [PW-1:0] POS_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [2:0] {S_IDLE, S_LAST, S_SCAN, S_BLEND, S_EMIT} state_t;

  function automatic logic [PW-1:0] sat_pos(input logic [PW-1:0] v);
    return (v > POS_ONE) ? POS_ONE : v;
  endfunction

  function automatic logic [EW-1:0] reset_entry(input logic [AW-1:0] a);
    logic [EW-1:0] e;
    e = '0;
    if (a == AW'(0)) begin
      e = {{PW{1'b0}}, grcl_pkg::COLOR_BLACK};
    end else if (a == AW'(1)) begin
      e = {POS_ONE, grcl_pkg::COLOR_WHITE};
    end
    return e;
  endfunction

  // request fields
  logic [SLOT_W-1:0] f_slot;
  logic [PW-1:0]     f_spos;
  logic [CW-1:0]     f_color;
  logic [PW-1:0]     f_qpos;

  assign f_slot  = in_tdata[SLOT_W-1:0];
  assign f_spos  = in_tdata[SLOT_W +: PW];
  // stored packed with red in the top byte
  assign f_color = {in_tdata[SLOT_W+PW +: CH_W],
                    in_tdata[SLOT_W+PW+CH_W +: CH_W],
                    in_tdata[SLOT_W+PW+2*CH_W +: CH_W],
                    in_tdata[SLOT_W+PW+3*CH_W +: CH_W]};
  assign f_qpos  = in_tdata[SLOT_W+PW+CW +: PW];

  state_t           state_r;
  logic [CNT_W-1:0] count_r;
  logic [MAX_STOPS-1:0] valid_r;
  logic             rd_valid_r;
  logic [AW-1:0]    rd_addr_r;
  logic [PW-1:0]    t_r;
  logic [AW-1:0]    idx_r;
  logic [PW-1:0]    plast_r;
  logic [CW-1:0]    clast_r;
  logic [PW-1:0]    prev_pos_r;
  logic [CW-1:0]    prev_col_r;
  logic [CW-1:0]    res_r;
  logic             out_valid_r;
  logic [CW-1:0]    out_data_r;

  logic             in_acc;
  logic             acc_load;
  logic             acc_eval;
  logic [AW-1:0]    n_last;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [EW-1:0]    ram_q;
  logic [EW-1:0]    ent;
  logic [PW-1:0]    ent_pos;
  logic [CW-1:0]    ent_col;
  logic             at_first;
  logic             hit;
  logic             first_end;
  logic             hit_later;
  logic             advance;
  logic             blend_start;
  logic [PW-1:0]    blend_span;
  logic [PW-1:0]    blend_offs;
  logic [CW-1:0]    blend_res;
  grcl_pkg::blend_sts_t blend_sts;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign acc_load  = in_acc && (in_tuser == grcl_pkg::CMD_LOAD);
  assign acc_eval  = in_acc && (in_tuser == grcl_pkg::CMD_EVAL);

  // last slot in use, count clamped to [2, MAX_STOPS]
  always_comb begin
    if (count_r < CNT_W'(2)) begin
      n_last = AW'(1);
    end else if (32'(count_r) > 32'(MAX_STOPS)) begin
      n_last = AW'(MAX_STOPS - 1);
    end else begin
      n_last = AW'(count_r - 1'b1);
    end
  end

  assign wr_en   = acc_load && (32'(f_slot) < 32'(MAX_STOPS));
  assign wr_addr = AW'(f_slot);

  // table entry as seen in the cycle after the read
  assign ent     = rd_valid_r ? ram_q : reset_entry(rd_addr_r);
  assign ent_pos = ent[EW-1 -: PW];
  assign ent_col = ent[CW-1:0];

  assign at_first    = (idx_r == '0);
  assign hit         = (t_r <= ent_pos);
  assign first_end   = at_first && (hit || (t_r >= plast_r));
  assign hit_later   = !at_first && hit;
  assign advance     = (state_r == S_SCAN) && !first_end && !hit_later;
  assign blend_start = (state_r == S_SCAN) && hit_later && (ent_pos > prev_pos_r);
  assign blend_span  = ent_pos - prev_pos_r;
  // the scan only moves past stops that lie below the query
  assign blend_offs  = t_r - prev_pos_r;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state_r)
      S_IDLE: begin
        rd_en   = acc_eval;
        rd_addr = n_last;
      end
      S_LAST: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      S_SCAN: begin
        rd_en   = advance;
        rd_addr = idx_r + 1'b1;
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = '0;
      end
    endcase
  end

  grcl_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_STOPS)
  ) u_stop_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata ({sat_pos(f_spos), f_color}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  grcl_blend #(
    .PW (PW)
  ) u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (blend_start),
    .color_lo (prev_col_r),
    .color_hi (ent_col),
    .span     (blend_span),
    .offs     (blend_offs),
    .sts      (blend_sts),
    .result   (blend_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CNT_W'(2);
      valid_r     <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
        rd_addr_r  <= rd_addr;
      end
      // a hand-off in the emit state reloads the register below
      if (out_valid_r && out_tready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (acc_eval) begin
            t_r     <= sat_pos(f_qpos);
            state_r <= S_LAST;
          end
        end
        S_LAST: begin
          plast_r <= ent_pos;
          clast_r <= ent_col;
          idx_r   <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (at_first && hit) begin
            res_r   <= ent_col;
            state_r <= S_EMIT;
          end else if (first_end) begin
            res_r   <= clast_r;
            state_r <= S_EMIT;
          end else if (hit_later) begin
            if (blend_start) begin
              state_r <= S_BLEND;
            end else begin
              // zero span gives the lower stop
              res_r   <= prev_col_r;
              state_r <= S_EMIT;
            end
          end else begin
            prev_pos_r <= ent_pos;
            prev_col_r <= ent_col;
            idx_r      <= idx_r + 1'b1;
          end
        end
        S_BLEND: begin
          if (blend_sts.done) begin
            res_r   <= blend_res;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {res_r[CH_W-1:0], res_r[2*CH_W-1:CH_W],
                            res_r[3*CH_W-1:2*CH_W], res_r[CW-1:3*CH_W]};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `ASSERT_CLK(a_load_no_result, clk, rst_n, (acc_load && !out_tvalid) |=> !out_tvalid)
  `ASSERT_CLK(a_eval_holds_input, clk, rst_n, acc_eval |=> !in_tready)
  `ASSERT_CLK(a_scan_below_query, clk, rst_n, (state_r == S_SCAN && !at_first) |-> (t_r > prev_pos_r))
  `ASSERT_NEVER(a_blend_overlap, clk, rst_n, blend_start && blend_sts.busy)

endmodule
